[rtl/core/wildcard_glob_matcher_core_macros.svh]
// Assertion macros for the glob matcher checker.
`ifndef WILDCARD_GLOB_MATCHER_CORE_MACROS_SVH
`define WILDCARD_GLOB_MATCHER_CORE_MACROS_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define WGM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("glob matcher assertion failed");

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define WGM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("glob matcher assertion failed");

`endif

[rtl/core/wgm_pkg.sv]
// Package: constants, register codes and helpers for the glob matcher.
package wgm_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 64;
    localparam int LEN_W           = 5;

    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_QMARK = 8'h3F;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    typedef enum logic [1:0] {
        REG_PAT_LO  = 2'd0,
        REG_PAT_HI  = 2'd1,
        REG_PAT_LEN = 2'd2
    } reg_idx_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
            return c + CASE_DELTA;
        end
        return c;
    endfunction

endpackage

[rtl/core/wgm_step.sv]
// Automaton update: star closure, one-byte advance, closure again; an empty name gets the first closure only.
module wgm_step #(
    parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF,
    localparam int SetW = PATTERN_MAX + 1,
    localparam int LenW = $clog2(PATTERN_MAX + 1)
) (
    input  logic [2*wgm_pkg::DATA_W-1:0] pattern,
    input  logic [LenW-1:0]              len,
    input  logic [SetW-1:0]              active,
    input  logic [7:0]                   name_byte,
    input  logic                         empty,
    output logic [SetW-1:0]              set_out
);

    logic [SetW-1:0] star;
    logic [SetW-1:0] hit;
    logic [SetW-1:0] cur;
    logic [SetW-1:0] stepped;

    // Runs of stars propagate like an adder carry chain.
    function automatic logic [SetW-1:0] close_set(input logic [SetW-1:0] s,
                                                  input logic [SetW-1:0] st);
        logic [SetW-1:0] g;
        logic [SetW-1:0] c;
        g = s & st;
        c = (g + st) ^ g ^ st;
        return s | c;
    endfunction

    always_comb begin
        star = '0;
        hit  = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (LenW'(i) < len) begin
                if (pattern[8*i +: 8] == wgm_pkg::CHAR_STAR) begin
                    star[i] = 1'b1;
                end else if (pattern[8*i +: 8] == wgm_pkg::CHAR_QMARK ||
                             wgm_pkg::fold_case(pattern[8*i +: 8]) ==
                             wgm_pkg::fold_case(name_byte)) begin
                    hit[i] = 1'b1;
                end
            end
        end
    end

    assign cur     = close_set(active, star);
    assign stepped = (cur & star) | ((cur & hit) << 1);
    assign set_out = empty ? cur : close_set(stepped, star);

endmodule

[rtl/core/wildcard_glob_matcher_core.sv]
// Top level: glob pattern matcher over a streamed file name.
//
//  channel   | dir | fields
//  s_ stream | in  | name_byte (tdata), last_byte (tlast), empty_name (tuser)
//  m_ stream | out | matched (tdata[0])
//  APB cfg   | in  | pattern bytes low/high, pattern length
//
//  One word per cycle while the result is not stalled; each word goes through
//  the input register, then the set update into the result register.
//  The critical path is the two 17-bit carry-chain adds of the star closure.
//  Reset clears the pattern registers and returns the active set to position 0.
//  A stalled result holds; words inside a name keep flowing, and the word that
//  ends the next name waits in the input register until the result is taken.
module wildcard_glob_matcher_core #(
    parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] name_byte
    input  logic                        s_tlast,
    input  logic                        s_tuser,   // [0] empty_name
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [0] matched, [7:1] zero
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wgm_pkg::ADDR_W-1:0]  paddr,
    input  logic [wgm_pkg::DATA_W-1:0]  pwdata,
    output logic [wgm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int SetW = PATTERN_MAX + 1;
    localparam int LenW = $clog2(PATTERN_MAX + 1);

    logic [wgm_pkg::DATA_W-1:0] pat_lo_reg;
    logic [wgm_pkg::DATA_W-1:0] pat_hi_reg;
    logic [wgm_pkg::LEN_W-1:0]  pat_len_reg;
    logic [LenW-1:0]            len;
    logic                       wr_en;
    wgm_pkg::reg_idx_t          reg_idx;

    logic                       in_valid_reg;
    logic [7:0]                 in_byte_reg;
    logic                       in_last_reg;
    logic                       in_empty_reg;
    logic [SetW-1:0]            active_reg;
    logic                       out_valid_reg;
    logic                       out_match_reg;

    logic [SetW-1:0]            step_set;
    logic                       ends_name;
    logic                       out_free;
    logic                       advance;
    logic                       all_files;
    logic                       matched;

    // Configuration port
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = wgm_pkg::reg_idx_t'(paddr[4:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo_reg  <= '0;
            pat_hi_reg  <= '0;
            pat_len_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                wgm_pkg::REG_PAT_LO:  pat_lo_reg  <= pwdata;
                wgm_pkg::REG_PAT_HI:  pat_hi_reg  <= pwdata;
                wgm_pkg::REG_PAT_LEN: pat_len_reg <= pwdata[wgm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            wgm_pkg::REG_PAT_LO:  prdata = pat_lo_reg;
            wgm_pkg::REG_PAT_HI:  prdata = pat_hi_reg;
            wgm_pkg::REG_PAT_LEN: prdata = wgm_pkg::DATA_W'(pat_len_reg);
            default:              prdata = '0;
        endcase
    end

    // Saturated pattern length
    always_comb begin
        if (pat_len_reg > wgm_pkg::LEN_W'(PATTERN_MAX)) begin
            len = LenW'(PATTERN_MAX);
        end else begin
            len = pat_len_reg[LenW-1:0];
        end
    end

    wgm_step #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_wgm_step (
        .pattern   ({pat_hi_reg, pat_lo_reg}),
        .len       (len),
        .active    (active_reg),
        .name_byte (in_byte_reg),
        .empty     (in_empty_reg),
        .set_out   (step_set)
    );

    // "*.*" matches every name
    assign all_files = (wgm_pkg::LEN_W'(len) == wgm_pkg::LEN_W'(3)) &&
                       (pat_lo_reg[7:0]   == wgm_pkg::CHAR_STAR) &&
                       (pat_lo_reg[15:8]  == wgm_pkg::CHAR_DOT) &&
                       (pat_lo_reg[23:16] == wgm_pkg::CHAR_STAR);
    assign matched   = all_files | step_set[len];

    // Flow control
    assign ends_name = in_last_reg | in_empty_reg;
    assign out_free  = !out_valid_reg | m_tready;
    assign advance   = in_valid_reg & (!ends_name | out_free);
    assign s_tready  = !in_valid_reg | advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            active_reg    <= SetW'(1);
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                active_reg <= ends_name ? SetW'(1) : step_set;
            end
            if (advance && ends_name) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_last_reg  <= s_tlast;
            in_empty_reg <= s_tuser;
        end
        if (advance && ends_name) begin
            out_match_reg <= matched;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_match_reg};

endmodule

[rtl/core/wgm_checker.sv]
// Port-level checker for the glob matcher, bound to the top level.
`include "wildcard_glob_matcher_core_macros.svh"

module wgm_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [7:0]                  m_tdata,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [wgm_pkg::ADDR_W-1:0]  paddr,
    input logic [wgm_pkg::DATA_W-1:0]  pwdata,
    input logic [wgm_pkg::DATA_W-1:0]  prdata,
    input logic                        pready
);

    // stalled result word holds
    `WGM_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // with the result register empty, the input side never stalls
    `WGM_ASSERT_IMP(a_in_ready, !m_tvalid, s_tready)

    // pattern low word reads back what was just written
    `WGM_ASSERT_IMP(a_cfg_readback, (psel && penable && pwrite && pready && paddr[4:3] == wgm_pkg::REG_PAT_LO) ##1 (psel && !pwrite && paddr[4:3] == wgm_pkg::REG_PAT_LO), prdata == $past(pwdata))

endmodule

bind wildcard_glob_matcher_core wgm_checker u_wgm_checker (.*);
